/* rtl/fstrm_pkg.sv */
// Package for the flow switch toggle rate monitor.
// Holds the beat payload types, configuration struct and operation and level codes.
// No dependencies.
`default_nettype none

package fstrm_pkg;

  // Operation codes carried in the input beat
  localparam logic [2:0] OP_START   = 3'd0;
  localparam logic [2:0] OP_STOP    = 3'd1;
  localparam logic [2:0] OP_SEC     = 3'd2;
  localparam logic [2:0] OP_100MS   = 3'd3;
  localparam logic [2:0] OP_10MS    = 3'd4;
  localparam logic [2:0] OP_INSTANT = 3'd5;

  // Switch level codes
  localparam logic [1:0] LVL_NONE = 2'd0;
  localparam logic [1:0] LVL_HIGH = 2'd1;
  localparam logic [1:0] LVL_LOW  = 2'd2;

  // Reported mode codes
  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_READY  = 2'd1;
  localparam logic [1:0] MODE_ACTIVE = 2'd2;

  // Configuration register indexes
  localparam logic REG_LOW_LIMIT  = 1'b0;
  localparam logic REG_HIGH_LIMIT = 1'b1;

  localparam logic [15:0] LOW_LIMIT_RST  = 16'd5;
  localparam logic [15:0] HIGH_LIMIT_RST = 16'd1000;

  typedef struct packed {
    logic [2:0] operation;
    logic [1:0] level_report;
  } in_beat_t;

  typedef struct packed {
    logic        clear_alarms;
    logic        low_flow_alarm;
    logic        high_flow_alarm;
    logic [1:0]  mode;
    logic [15:0] window_count;
  } out_beat_t;

  typedef struct packed {
    logic [15:0] low_limit;
    logic [15:0] high_limit;
  } limits_t;

endpackage

`default_nettype wire

/* rtl/fstrm_cfg.sv */
// Configuration registers of the flow switch toggle rate monitor.
// Depends on fstrm_pkg for the limits struct, register indexes and reset values.
`default_nettype none

module fstrm_cfg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [15:0]       cfg_data,
  output fstrm_pkg::limits_t     limits
);

  fstrm_pkg::limits_t limits_r;

  // Take a register write; reset restores the default band
  always_ff @(posedge clk) begin
    if (rst) begin
      limits_r.low_limit  <= fstrm_pkg::LOW_LIMIT_RST;
      limits_r.high_limit <= fstrm_pkg::HIGH_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fstrm_pkg::REG_LOW_LIMIT:  limits_r.low_limit  <= cfg_data;
        fstrm_pkg::REG_HIGH_LIMIT: limits_r.high_limit <= cfg_data;
      endcase
    end
  end

  assign limits = limits_r;

endmodule

`default_nettype wire

/* rtl/fstrm_core.sv */
// Mode controller and toggle counter of the flow switch toggle rate monitor.
// Updates its state once per beat and forms the result. Depends on fstrm_pkg.
`default_nettype none

module fstrm_core #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 fire,
  input  wire fstrm_pkg::in_beat_t  beat,
  input  wire fstrm_pkg::limits_t   limits,
  output fstrm_pkg::out_beat_t      result
);

  localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_READY  = 3'b010,
    ST_ACTIVE = 3'b100
  } mode_state_t;

  mode_state_t            state, state_next;
  logic [1:0]             last_level, last_level_next;
  logic [1:0]             pending, pending_next;
  logic [COUNT_WIDTH-1:0] counter, counter_next;

  logic [1:0]             pend_eff;
  logic                   consume;
  logic                   clr, lo, hi;
  logic [CMP_W-1:0]       cnt_ext, cnt_out_ext;
  logic                   cnt_sat16;

  // Latch a fresh report ahead of the operation
  assign pend_eff = (beat.level_report == fstrm_pkg::LVL_HIGH ||
                     beat.level_report == fstrm_pkg::LVL_LOW) ? beat.level_report : pending;

  assign cnt_ext = CMP_W'(counter);

  // Mode transitions, alarm checks and report consumption
  always_comb begin
    state_next      = state;
    consume         = 1'b0;
    clr             = 1'b0;
    lo              = 1'b0;
    hi              = 1'b0;
    counter_next    = counter;
    last_level_next = last_level;
    pending_next    = pend_eff;

    case (state)
      ST_IDLE: begin
        if (beat.operation == fstrm_pkg::OP_START) state_next = ST_READY;
      end
      ST_READY: begin
        if (beat.operation == fstrm_pkg::OP_SEC) state_next = ST_ACTIVE;
        else if (beat.operation == fstrm_pkg::OP_INSTANT) consume = 1'b1;
      end
      ST_ACTIVE: begin
        if (beat.operation == fstrm_pkg::OP_STOP) begin
          state_next = ST_IDLE;
        end else if (beat.operation == fstrm_pkg::OP_SEC) begin
          clr = 1'b1;
          lo  = cnt_ext < CMP_W'(limits.low_limit);
          hi  = cnt_ext > CMP_W'(limits.high_limit);
          if (lo || hi) state_next = ST_IDLE;
        end else if (beat.operation == fstrm_pkg::OP_10MS ||
                     beat.operation == fstrm_pkg::OP_INSTANT) begin
          consume = 1'b1;
        end
      end
      default: state_next = ST_IDLE;
    endcase

    // Count a level change, saturating at all ones
    if (consume && (pend_eff == fstrm_pkg::LVL_HIGH || pend_eff == fstrm_pkg::LVL_LOW)) begin
      pending_next = fstrm_pkg::LVL_NONE;
      if (last_level != pend_eff) begin
        last_level_next = pend_eff;
        if (counter != {COUNT_WIDTH{1'b1}}) counter_next = counter + COUNT_WIDTH'(1);
      end
    end

    // Zero the window after the second check
    if (clr) counter_next = '0;
  end

  // Advance state on each beat taken
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      last_level <= fstrm_pkg::LVL_NONE;
      pending    <= fstrm_pkg::LVL_NONE;
      counter    <= '0;
    end else if (fire) begin
      state      <= state_next;
      last_level <= last_level_next;
      pending    <= pending_next;
      counter    <= counter_next;
    end
  end

  // Result fields from the state after the step
  assign cnt_out_ext = CMP_W'(counter_next);
  assign cnt_sat16   = (cnt_out_ext >> 16) != '0;

  always_comb begin
    result.clear_alarms    = clr;
    result.low_flow_alarm  = lo;
    result.high_flow_alarm = hi;
    result.window_count    = cnt_sat16 ? 16'hFFFF : cnt_out_ext[15:0];
    case (state_next)
      ST_READY:  result.mode = fstrm_pkg::MODE_READY;
      ST_ACTIVE: result.mode = fstrm_pkg::MODE_ACTIVE;
      default:   result.mode = fstrm_pkg::MODE_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/flow_switch_toggle_rate_monitor_top.sv */
// Flow switch toggle rate monitor: counts switch level changes per one-second window
// and raises low or high flow alarms. Top level with beat registers and checks.
// Depends on fstrm_pkg, fstrm_cfg and fstrm_core.
`default_nettype none

// The monitor takes one event beat per clock while not stalled and returns one
// result beat for each. A beat is captured in an input register; the controller and
// counter update as it passes to the result register, which then offers its result.
// A new beat can be taken every cycle as long as results are drained. Input stall
// rises only when the result register is full and held by out_stall. The user must
// write the limits through the cfg port while no beat is in flight; the block does not enforce it.

module flow_switch_toggle_rate_monitor_top #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output      logic                in_stall,
  input  wire fstrm_pkg::in_beat_t in_data,
  output      logic                out_valid,
  input  wire logic                out_stall,
  output fstrm_pkg::out_beat_t     out_data,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [15:0]         cfg_data
);

  fstrm_pkg::limits_t   limits;
  fstrm_pkg::in_beat_t  in_reg;
  logic                 in_reg_valid;
  fstrm_pkg::out_beat_t result;
  fstrm_pkg::out_beat_t out_reg;
  logic                 out_reg_valid;
  logic                 advance;
  logic                 in_take;

  assign advance  = !out_reg_valid || !out_stall;
  assign in_stall = in_reg_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  fstrm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .limits    (limits)
  );

  fstrm_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (in_reg_valid && advance),
    .beat   (in_reg),
    .limits (limits),
    .result (result)
  );

  // Input register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_reg <= in_data;
    end
  end

  // Result register: advance when empty or drained
  always_ff @(posedge clk) begin
    if (rst) begin
      out_reg_valid <= 1'b0;
    end else if (advance) begin
      out_reg_valid <= in_reg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_reg_valid) begin
      out_reg <= result;
    end
  end

  assign out_valid = out_reg_valid;
  assign out_data  = out_reg;

  // Checks
  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while result register could advance");

  a_alarm_needs_clear: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.low_flow_alarm || out_data.high_flow_alarm))
      |-> out_data.clear_alarms)
    else $error("alarm raised outside a second check");

  a_alarm_goes_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.low_flow_alarm || out_data.high_flow_alarm))
      |-> (out_data.mode == fstrm_pkg::MODE_IDLE))
    else $error("alarm did not return controller to idle");

  a_clear_zeroes_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.clear_alarms) |-> (out_data.window_count == 16'd0))
    else $error("window count not zeroed on second check");

endmodule

`default_nettype wire
